/* sv/fclim_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fclim_pkg
// Shared types and constants for the foldback current limiter.
// ----------------------------------------------------------------------------
package fclim_pkg;

    // Field widths fixed by the interface.
    localparam int CUR_W   = 12;
    localparam int TIME_W  = 32;
    localparam int WGT_W   = 9;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Filter weight is expressed out of this full-scale value.
    localparam int WGT_SHIFT = 8;
    localparam logic [WGT_W-1:0] WGT_FULL = WGT_W'(256);
    localparam logic [WGT_W-1:0] WGT_RESET = WGT_W'(230);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_USE_LEGACY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEGACY_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_TIME     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FOLD_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FOLD_TIME     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_WEIGHT = 3'd6;

    // Limit mode codes.
    localparam logic [MODE_W-1:0] MODE_LEGACY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PEAK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FOLD   = 2'd2;

    // Limiter settings as seen by the mode controller.
    typedef struct packed {
        logic              use_legacy;
        logic [CUR_W-1:0]  legacy_limit;
        logic [CUR_W-1:0]  peak_limit;
        logic [TIME_W-1:0] peak_time_ms;
        logic [CUR_W-1:0]  foldback_limit;
        logic [TIME_W-1:0] foldback_time_ms;
    } t_lim_cfg;

    // Result of the mode decision for one sample.
    typedef struct packed {
        logic [CUR_W-1:0]  limit;
        logic [MODE_W-1:0] mode;
    } t_lim_res;

endpackage

/* sv/foldback_current_limiter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foldback_current_limiter_core
// Filters motor-current samples and picks the legacy, peak or foldback limit.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the input channel (i_valid / o_ready) with a current
// value and a millisecond timestamp. Each accepted transaction yields exactly
// one result transaction (o_valid / i_ready) carrying the filtered current,
// the applied limit and the limit mode.
// A transaction accepted at the input is registered in the input stage,
// processed by the filter and mode logic, and registered in the output
// register, from which the receiver takes it. Throughput is one transaction
// per cycle while the receiver does not stall, set by the combinational
// filter multiply and mode update.
// When the receiver stalls, the output register holds its result and the
// input stage keeps taking one more transaction before o_ready drops.
// Settings are to be written via i_cfg_we / i_cfg_idx / i_cfg_data only while
// the block is idle; it does not enforce this. Writing the mode, peak or
// foldback settings returns the limiter to peak mode with the timer idle.
// Reset clears the filter, the mode state and the settings, weight to 230 of 256.
// ----------------------------------------------------------------------------
module foldback_current_limiter_core #(
    parameter int FILTER_FRAC_BITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [fclim_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [fclim_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [fclim_pkg::CUR_W-1:0]           i_current_sample,
    input  logic [fclim_pkg::TIME_W-1:0]          i_now_ms,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [fclim_pkg::CUR_W-1:0]           o_filtered_current,
    output logic [fclim_pkg::CUR_W-1:0]           o_applied_limit,
    output logic [fclim_pkg::MODE_W-1:0]          o_limit_mode
);

    localparam int ACC_W = fclim_pkg::CUR_W + FILTER_FRAC_BITS;

    fclim_pkg::t_lim_cfg            r_cfg;
    logic [fclim_pkg::WGT_W-1:0]    r_weight;
    logic                           r_s1_valid;
    logic [fclim_pkg::CUR_W-1:0]    r_s1_sample;
    logic [fclim_pkg::TIME_W-1:0]   r_s1_now;
    logic                           r_out_valid;
    logic [fclim_pkg::CUR_W-1:0]    r_out_cur;
    fclim_pkg::t_lim_res            r_out_res;
    logic                           adv;
    logic                           clr_peak;
    logic [ACC_W-1:0]               acc_next;
    fclim_pkg::t_lim_res            res;

    // Pipeline control: the process stage moves when the output can take it.
    assign adv     = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || adv;

    // Settings that send the limiter back to peak mode.
    assign clr_peak = i_cfg_we && ((i_cfg_idx == fclim_pkg::REG_USE_LEGACY)
                                || (i_cfg_idx == fclim_pkg::REG_PEAK_LIMIT)
                                || (i_cfg_idx == fclim_pkg::REG_PEAK_TIME)
                                || (i_cfg_idx == fclim_pkg::REG_FOLD_LIMIT)
                                || (i_cfg_idx == fclim_pkg::REG_FOLD_TIME));

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= '0;
            r_weight <= fclim_pkg::WGT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fclim_pkg::REG_USE_LEGACY: begin
                    r_cfg.use_legacy <= i_cfg_data[0];
                end
                fclim_pkg::REG_LEGACY_LIMIT: begin
                    r_cfg.legacy_limit <= i_cfg_data[fclim_pkg::CUR_W-1:0];
                end
                fclim_pkg::REG_PEAK_LIMIT: begin
                    r_cfg.peak_limit <= i_cfg_data[fclim_pkg::CUR_W-1:0];
                end
                fclim_pkg::REG_PEAK_TIME: begin
                    r_cfg.peak_time_ms <= i_cfg_data[fclim_pkg::TIME_W-1:0];
                end
                fclim_pkg::REG_FOLD_LIMIT: begin
                    r_cfg.foldback_limit <= i_cfg_data[fclim_pkg::CUR_W-1:0];
                end
                fclim_pkg::REG_FOLD_TIME: begin
                    r_cfg.foldback_time_ms <= i_cfg_data[fclim_pkg::TIME_W-1:0];
                end
                fclim_pkg::REG_FILTER_WEIGHT: begin
                    r_weight <= i_cfg_data[fclim_pkg::WGT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input stage: capture the sample and its timestamp.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s1_sample <= i_current_sample;
            r_s1_now    <= i_now_ms;
        end
    end

    fclim_filter #(
        .FRAC_BITS (FILTER_FRAC_BITS)
    ) u_filter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_sample   (r_s1_sample),
        .i_weight   (r_weight),
        .o_acc_next (acc_next)
    );

    fclim_mode #(
        .FRAC_BITS (FILTER_FRAC_BITS)
    ) u_mode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_clr_peak (clr_peak),
        .i_cfg      (r_cfg),
        .i_acc      (acc_next),
        .i_now_ms   (r_s1_now),
        .o_res      (res)
    );

    // Output register: holds the result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_cur <= acc_next[ACC_W-1:FILTER_FRAC_BITS];
            r_out_res <= res;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_filtered_current = r_out_cur;
    assign o_applied_limit    = r_out_res.limit;
    assign o_limit_mode       = r_out_res.mode;

endmodule

/* sv/fclim_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fclim_filter
// First-order exponential smoothing filter with a fixed-point accumulator.
// ----------------------------------------------------------------------------
module fclim_filter #(
    parameter int FRAC_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_adv,
    input  logic [fclim_pkg::CUR_W-1:0]        i_sample,
    input  logic [fclim_pkg::WGT_W-1:0]        i_weight,
    output logic [fclim_pkg::CUR_W+FRAC_BITS-1:0] o_acc_next
);

    localparam int ACC_W  = fclim_pkg::CUR_W + FRAC_BITS;
    localparam int PROD_W = ACC_W + fclim_pkg::WGT_W;
    localparam int SUM_W  = PROD_W + 1;

    logic [ACC_W-1:0]             r_acc;
    logic [fclim_pkg::WGT_W-1:0]  w_old;
    logic [fclim_pkg::WGT_W-1:0]  w_new;
    logic [ACC_W-1:0]             sample_fx;
    logic [PROD_W-1:0]            prod_old;
    logic [PROD_W-1:0]            prod_new;
    logic [SUM_W-1:0]             sum;

    // Weights above full scale behave as full scale, so the filter holds.
    assign w_old = (i_weight > fclim_pkg::WGT_FULL) ? fclim_pkg::WGT_FULL : i_weight;
    assign w_new = fclim_pkg::WGT_FULL - w_old;

    // Blend old value and new sample, then drop the weight scale.
    assign sample_fx = {i_sample, {FRAC_BITS{1'b0}}};
    assign prod_old  = PROD_W'(w_old) * PROD_W'(r_acc);
    assign prod_new  = PROD_W'(w_new) * PROD_W'(sample_fx);
    assign sum       = SUM_W'(prod_old) + SUM_W'(prod_new);
    assign o_acc_next = sum[fclim_pkg::WGT_SHIFT +: ACC_W];

    // Accumulator follows every processed sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_adv) begin
            r_acc <= o_acc_next;
        end
    end

endmodule

/* sv/fclim_mode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fclim_mode
// Peak / foldback mode controller with its overcurrent timer.
// ----------------------------------------------------------------------------
module fclim_mode #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_adv,
    input  logic                                  i_clr_peak,
    input  fclim_pkg::t_lim_cfg                   i_cfg,
    input  logic [fclim_pkg::CUR_W+FRAC_BITS-1:0] i_acc,
    input  logic [fclim_pkg::TIME_W-1:0]          i_now_ms,
    output fclim_pkg::t_lim_res                   o_res
);

    localparam int ACC_W = fclim_pkg::CUR_W + FRAC_BITS;

    logic                         r_fold;
    logic                         r_run;
    logic [fclim_pkg::TIME_W-1:0] r_start;
    logic                         n_fold;
    logic                         n_run;
    logic [fclim_pkg::TIME_W-1:0] n_start;
    logic [ACC_W-1:0]             peak_fx;
    logic                         above;
    logic [fclim_pkg::TIME_W-1:0] base;
    logic [fclim_pkg::TIME_W-1:0] run_elapsed;
    logic [fclim_pkg::TIME_W-1:0] fold_elapsed;

    // Threshold compare at full accumulator precision.
    assign peak_fx = {i_cfg.peak_limit, {FRAC_BITS{1'b0}}};
    assign above   = i_acc > peak_fx;

    // The timer base is the current time when the timer is just starting.
    assign base         = r_run ? r_start : i_now_ms;
    assign run_elapsed  = i_now_ms - base;
    assign fold_elapsed = i_now_ms - r_start;

    // Next mode state and the limit that goes with it.
    always_comb begin
        n_fold  = r_fold;
        n_run   = r_run;
        n_start = r_start;
        if (i_cfg.use_legacy) begin
            n_fold = 1'b0;
            n_run  = 1'b0;
        end else if (!r_fold) begin
            if (!above) begin
                n_run = 1'b0;
            end else begin
                n_run   = 1'b1;
                n_start = base;
                if (run_elapsed > i_cfg.peak_time_ms) begin
                    n_start = i_now_ms;
                    n_fold  = 1'b1;
                end
            end
        end else if (fold_elapsed > i_cfg.foldback_time_ms) begin
            n_fold = 1'b0;
            n_run  = 1'b0;
        end

        if (i_cfg.use_legacy) begin
            o_res.limit = i_cfg.legacy_limit;
            o_res.mode  = fclim_pkg::MODE_LEGACY;
        end else if (n_fold) begin
            o_res.limit = i_cfg.foldback_limit;
            o_res.mode  = fclim_pkg::MODE_FOLD;
        end else begin
            o_res.limit = i_cfg.peak_limit;
            o_res.mode  = fclim_pkg::MODE_PEAK;
        end
    end

    // A mode, peak or foldback settings write returns the controller to peak mode, timer idle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold  <= 1'b0;
            r_run   <= 1'b0;
            r_start <= '0;
        end else if (i_clr_peak) begin
            r_fold <= 1'b0;
            r_run  <= 1'b0;
        end else if (i_adv) begin
            r_fold  <= n_fold;
            r_run   <= n_run;
            r_start <= n_start;
        end
    end

endmodule
